/* sv/tms_pkg.sv */
// Package for the Turing machine step core: transaction payload types, rule
// cell types, operation and register codes, and sequencer states.
// No dependencies.
package tms_pkg;

  localparam int CFG_DW = 11;

  localparam logic [10:0] TAPE_LENGTH_RST = 11'd1024;
  localparam logic [6:0]  RULE_COUNT_RST  = 7'd0;
  localparam logic [9:0]  START_HEAD_RST  = 10'd0;

  typedef enum logic [2:0] {
    OP_WR_RULE = 3'd0,
    OP_WR_TAPE = 3'd1,
    OP_STEP    = 3'd2,
    OP_RESTART = 3'd3,
    OP_RD_TAPE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_TAPE_LENGTH = 2'd0,
    REG_RULE_COUNT  = 2'd1,
    REG_START_HEAD  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SYM,
    ST_LAUNCH,
    ST_SEARCH,
    ST_RDWAIT,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] rule_index;
    logic [7:0] rule_state;
    logic [7:0] rule_symbol;
    logic [7:0] rule_new_symbol;
    logic       rule_move_right;
    logic [7:0] rule_new_state;
    logic [9:0] tape_address;
    logic [7:0] tape_symbol;
  } tms_in_t;

  typedef struct packed {
    logic [7:0]         state_now;
    logic signed [11:0] head_now;
    logic [7:0]         symbol_out;
    logic               halted;
    logic               off_tape;
    logic               rule_fired;
  } tms_out_t;

  typedef struct packed {
    logic [7:0] state;
    logic [7:0] symbol;
    logic [7:0] new_symbol;
    logic       move_right;
    logic [7:0] new_state;
  } tms_rule_t;

  typedef struct packed {
    logic      wr_en;
    logic [5:0] wr_index;
    tms_rule_t wr_rule;
    logic [7:0] key_state;
    logic [7:0] key_symbol;
    logic [6:0] rule_count;
  } tms_cell_ctl_t;

  typedef struct packed {
    logic       vld;
    logic       hit;
    logic [7:0] new_symbol;
    logic       move_right;
    logic [7:0] new_state;
  } tms_tok_t;

endpackage

/* sv/tms_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/tms_rule_cell.sv */
// One rule cell of the search chain: holds one rule and passes the search
// token to its neighbour each cycle. Depends on tms_pkg.
module tms_rule_cell #(
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tms_pkg::tms_cell_ctl_t ctl,
  input  tms_pkg::tms_tok_t      tok_in,
  output tms_pkg::tms_tok_t      tok_out
);
  import tms_pkg::*;

  tms_rule_t rule_r;
  tms_tok_t  tok_r;
  tms_tok_t  tok_nxt;
  logic      active;
  logic      match;

  always_ff @(posedge clk) begin
    if (ctl.wr_en && ({2'b00, ctl.wr_index} == 8'(IDX))) begin
      rule_r <= ctl.wr_rule;
    end
  end

  always_comb begin
    active = 9'(IDX) < {2'b00, ctl.rule_count};
    match  = active && (rule_r.state == ctl.key_state) &&
             (rule_r.symbol == ctl.key_symbol);
    tok_nxt = tok_in;
    if (tok_in.vld && !tok_in.hit && match) begin
      tok_nxt.hit        = 1'b1;
      tok_nxt.new_symbol = rule_r.new_symbol;
      tok_nxt.move_right = rule_r.move_right;
      tok_nxt.new_state  = rule_r.new_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

/* sv/turing_machine_step_core.sv */
// Turing machine step core. A step with the head on the tape reads the cell under it and
// sends a search token along the rule chain one cell per cycle; a miss halts it, and
// a hit writes the new symbol, moves the head and reads the new cell while on the tape.
// Other ops and an off-tape step go from decode to done, a tape read via a read wait.
// One at a time: the next transaction is taken the cycle after the result is registered.
// Synchronous active-low reset: state 0, head 0, register defaults, idle, nothing valid.
module turing_machine_step_core #(
  parameter int RULE_DEPTH = 64,
  parameter int TAPE_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tms_pkg::tms_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tms_pkg::tms_out_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [tms_pkg::CFG_DW-1:0]   cfg_data
);
  import tms_pkg::*;

  localparam int TAW = $clog2(TAPE_DEPTH);

  st_t                st_r, st_nxt;
  tms_in_t            itm_r, itm_nxt;
  logic [7:0]         state_r, state_nxt;
  logic signed [11:0] head_r, head_nxt;
  logic [7:0]         under_r, under_nxt;
  logic [7:0]         sym_r, sym_nxt;
  logic               halted_r, halted_nxt;
  logic               off_r, off_nxt;
  logic               fired_r, fired_nxt;
  logic               out_valid_r, out_valid_nxt;
  tms_out_t           out_data_r, out_data_nxt;

  logic [10:0] cfg_tape_length_r;
  logic [6:0]  cfg_rule_count_r;
  logic [9:0]  cfg_start_head_r;

  logic [10:0]        len_used;
  logic               taddr_ok;
  logic signed [11:0] head_step;

  logic           ram_we, ram_re;
  logic [TAW-1:0] ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  tms_cell_ctl_t cell_ctl;
  tms_tok_t      tok_launch;
  tms_tok_t      tok_chain [RULE_DEPTH+1];
  tms_tok_t      tok_last;

  function automatic logic on_tape(logic signed [11:0] h, logic [10:0] len);
    return !h[11] && (h[10:0] < len);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_tape_length_r <= TAPE_LENGTH_RST;
      cfg_rule_count_r  <= RULE_COUNT_RST;
      cfg_start_head_r  <= START_HEAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TAPE_LENGTH: cfg_tape_length_r <= cfg_data[10:0];
        REG_RULE_COUNT:  cfg_rule_count_r  <= cfg_data[6:0];
        REG_START_HEAD:  cfg_start_head_r  <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (17'(cfg_tape_length_r) > 17'(TAPE_DEPTH)) begin
      len_used = 11'(TAPE_DEPTH);
    end else begin
      len_used = cfg_tape_length_r;
    end
  end

  assign taddr_ok  = 17'(itm_r.tape_address) < 17'(TAPE_DEPTH);
  assign tok_last  = tok_chain[RULE_DEPTH];
  assign head_step = head_r + (tok_last.move_right ? 12'sd1 : -12'sd1);

  always_comb begin
    cell_ctl.wr_en      = (st_r == ST_DECODE) && (itm_r.op == OP_WR_RULE);
    cell_ctl.wr_index   = itm_r.rule_index;
    cell_ctl.wr_rule    = '{state:      itm_r.rule_state,
                            symbol:     itm_r.rule_symbol,
                            new_symbol: itm_r.rule_new_symbol,
                            move_right: itm_r.rule_move_right,
                            new_state:  itm_r.rule_new_state};
    cell_ctl.key_state  = state_r;
    cell_ctl.key_symbol = under_r;
    cell_ctl.rule_count = cfg_rule_count_r;
    tok_launch          = '0;
    tok_launch.vld      = (st_r == ST_LAUNCH);
  end

  assign tok_chain[0] = tok_launch;

  for (genvar g = 0; g < RULE_DEPTH; g++) begin : g_cell
    tms_rule_cell #(
      .IDX(g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (cell_ctl),
      .tok_in (tok_chain[g]),
      .tok_out(tok_chain[g+1])
    );
  end

  tms_ram #(
    .WIDTH(8),
    .DEPTH(TAPE_DEPTH)
  ) u_tape (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      state_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    itm_r      <= itm_nxt;
    under_r    <= under_nxt;
    sym_r      <= sym_nxt;
    halted_r   <= halted_nxt;
    off_r      <= off_nxt;
    fired_r    <= fired_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    itm_nxt       = itm_r;
    state_nxt     = state_r;
    head_nxt      = head_r;
    under_nxt     = under_r;
    sym_nxt       = sym_r;
    halted_nxt    = halted_r;
    off_nxt       = off_r;
    fired_nxt     = fired_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = TAW'(itm_r.tape_address);
    ram_wdata     = itm_r.tape_symbol;
    ram_re        = 1'b0;
    ram_raddr     = TAW'(itm_r.tape_address);
    in_stall      = (st_r != ST_IDLE);

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          itm_nxt = in_data;
          st_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        sym_nxt    = '0;
        halted_nxt = 1'b0;
        off_nxt    = 1'b0;
        fired_nxt  = 1'b0;
        st_nxt     = ST_DONE;
        unique case (itm_r.op)
          OP_WR_RULE: begin
          end
          OP_WR_TAPE: begin
            ram_we = taddr_ok;
          end
          OP_STEP: begin
            if (on_tape(head_r, len_used)) begin
              ram_re    = 1'b1;
              ram_raddr = TAW'(head_r[10:0]);
              st_nxt    = ST_SYM;
            end else begin
              off_nxt = 1'b1;
            end
          end
          OP_RESTART: begin
            state_nxt = '0;
            head_nxt  = $signed({2'b00, cfg_start_head_r});
          end
          OP_RD_TAPE: begin
            if (taddr_ok) begin
              ram_re = 1'b1;
              st_nxt = ST_RDWAIT;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SYM: begin
        under_nxt = ram_rdata;
        st_nxt    = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        st_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (tok_last.vld) begin
          if (tok_last.hit) begin
            ram_we    = 1'b1;
            ram_waddr = TAW'(head_r[10:0]);
            ram_wdata = tok_last.new_symbol;
            head_nxt  = head_step;
            state_nxt = tok_last.new_state;
            fired_nxt = 1'b1;
            if (on_tape(head_step, len_used)) begin
              ram_re    = 1'b1;
              ram_raddr = TAW'(head_step[10:0]);
              st_nxt    = ST_RDWAIT;
            end else begin
              st_nxt = ST_DONE;
            end
          end else begin
            halted_nxt = 1'b1;
            sym_nxt    = under_r;
            st_nxt     = ST_DONE;
          end
        end
      end
      ST_RDWAIT: begin
        sym_nxt = ram_rdata;
        st_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.state_now  = state_r;
          out_data_nxt.head_now   = head_r;
          out_data_nxt.symbol_out = sym_r;
          out_data_nxt.halted     = halted_r;
          out_data_nxt.off_tape   = off_r;
          out_data_nxt.rule_fired = fired_r;
          st_nxt                  = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.vld |-> st_r == ST_SEARCH)
    else $error("search token left the rule chain outside the search state");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_data_r.halted, out_data_r.off_tape,
                              out_data_r.rule_fired}))
    else $error("more than one step outcome flagged in a result");

  a_head_moves_one: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SEARCH && tok_last.vld && tok_last.hit) |=>
      (head_r == $past(head_r) + 12'sd1 || head_r == $past(head_r) - 12'sd1))
    else $error("fired rule did not move the head by exactly one cell");

endmodule

/* tb/sv/tms_step_checker.sv */
`timescale 1ns / 1ps
// Result checker for the Turing machine step core: it watches the input, result
// and register write channels, predicts each result and compares it field by field.
// Depends on tms_pkg for the payload types, operation codes and register codes.
module tms_step_checker
  import tms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  tms_in_t    in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  tms_out_t   out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output int         errors,
  output int         pending
);

  localparam int RULE_SLOTS = 64;
  localparam int TAPE_CELLS = 1024;

  tms_rule_t   rule_mem [RULE_SLOTS];
  logic [7:0]  tape_mem [TAPE_CELLS];
  logic [7:0]  mach_state;
  int          head_pos;
  logic [10:0] tape_len;
  logic [6:0]  rule_cnt;
  logic [9:0]  start_pos;
  tms_out_t    expected_q[$];
  int          err_count = 0;

  assign errors = err_count;

  function automatic tms_out_t advance_machine(tms_in_t it);
    tms_out_t   r;
    int         used;
    int         lim;
    int         hit_at;
    logic [7:0] under;
    r = '0;
    used = (tape_len > TAPE_CELLS) ? TAPE_CELLS : int'(tape_len);
    case (it.op)
      OP_WR_RULE: rule_mem[it.rule_index] = '{it.rule_state, it.rule_symbol,
                                              it.rule_new_symbol, it.rule_move_right,
                                              it.rule_new_state};
      OP_WR_TAPE: tape_mem[it.tape_address] = it.tape_symbol;
      OP_STEP: begin
        if (head_pos < 0 || head_pos >= used) begin
          r.off_tape = 1'b1;
        end else begin
          under = tape_mem[head_pos];
          lim = (rule_cnt > RULE_SLOTS) ? RULE_SLOTS : int'(rule_cnt);
          hit_at = -1;
          for (int i = 0; i < lim && hit_at < 0; i++) begin
            if (rule_mem[i].state == mach_state && rule_mem[i].symbol == under) begin
              hit_at = i;
            end
          end
          if (hit_at >= 0) begin
            tape_mem[head_pos] = rule_mem[hit_at].new_symbol;
            head_pos += rule_mem[hit_at].move_right ? 1 : -1;
            mach_state = rule_mem[hit_at].new_state;
            r.rule_fired = 1'b1;
            if (head_pos >= 0 && head_pos < used) begin
              r.symbol_out = tape_mem[head_pos];
            end
          end else begin
            r.halted = 1'b1;
            r.symbol_out = under;
          end
        end
      end
      OP_RESTART: begin
        mach_state = '0;
        head_pos = int'(start_pos);
      end
      OP_RD_TAPE: r.symbol_out = tape_mem[it.tape_address];
      default: ;
    endcase
    r.state_now = mach_state;
    r.head_now = 12'(head_pos);
    return r;
  endfunction

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    tms_out_t want;
    if (!rst_n) begin
      mach_state = '0;
      head_pos = 0;
      tape_len = TAPE_LENGTH_RST;
      rule_cnt = RULE_COUNT_RST;
      start_pos = START_HEAD_RST;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_TAPE_LENGTH: tape_len = cfg_data[10:0];
          REG_RULE_COUNT:  rule_cnt = cfg_data[6:0];
          REG_START_HEAD:  start_pos = cfg_data[9:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected, actual %h",
                   $time, out_data);
          err_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("state_now", 12'(want.state_now), 12'(out_data.state_now));
          check_field("head_now", want.head_now, out_data.head_now);
          check_field("symbol_out", 12'(want.symbol_out), 12'(out_data.symbol_out));
          check_field("halted", 12'(want.halted), 12'(out_data.halted));
          check_field("off_tape", 12'(want.off_tape), 12'(out_data.off_tape));
          check_field("rule_fired", 12'(want.rule_fired), 12'(out_data.rule_fired));
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(advance_machine(in_data));
      end
      pending <= expected_q.size();
    end
  end

endmodule

/* tb/sv/tb_turing_machine_step_core.sv */
`timescale 1ns / 1ps
// Top of the Turing machine step core testbench: clock, reset, stimulus, result
// stall pattern, watchdog and verdict. Depends on tms_pkg, the core and tms_step_checker.
module tb_turing_machine_step_core;
  import tms_pkg::*;

  localparam int RULE_SLOTS     = 64;
  localparam int TAPE_CELLS     = 1024;
  localparam int ITEM_TARGET    = 1450;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 100;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  tms_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  tms_out_t          out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  int                errors;
  int                pending;

  bit tape_done [TAPE_CELLS];
  bit rule_done [RULE_SLOTS];
  int written_cells[$];
  int items_sent = 0;
  int burst_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int cur_tlen = 1024;
  int cur_rcnt = 0;
  int cur_start = 0;

  turing_machine_step_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tms_step_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] pick_small();
    return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  function automatic tms_in_t random_item(logic [2:0] op);
    tms_in_t it;
    it.op = op;
    it.rule_index = 6'($urandom);
    it.rule_state = 8'($urandom);
    it.rule_symbol = 8'($urandom);
    it.rule_new_symbol = 8'($urandom);
    it.rule_move_right = 1'($urandom);
    it.rule_new_state = 8'($urandom);
    it.tape_address = 10'($urandom);
    it.tape_symbol = 8'($urandom);
    return it;
  endfunction

  function automatic tms_in_t rule_entry(int idx, logic [7:0] st, logic [7:0] sym,
                                         logic [7:0] nsym, logic right, logic [7:0] nst);
    tms_in_t it;
    it = random_item(OP_WR_RULE);
    it.rule_index = 6'(idx);
    it.rule_state = st;
    it.rule_symbol = sym;
    it.rule_new_symbol = nsym;
    it.rule_move_right = right;
    it.rule_new_state = nst;
    return it;
  endfunction

  function automatic tms_in_t random_rule(int idx);
    return rule_entry(idx, pick_small(), pick_small(), pick_small(), 1'($urandom),
                      pick_small());
  endfunction

  function automatic tms_in_t tape_write(int addr, logic [7:0] sym);
    tms_in_t it;
    it = random_item(OP_WR_TAPE);
    it.tape_address = 10'(addr);
    it.tape_symbol = sym;
    return it;
  endfunction

  function automatic tms_in_t tape_read(int addr);
    tms_in_t it;
    it = random_item(OP_RD_TAPE);
    it.tape_address = 10'(addr);
    return it;
  endfunction

  // Side traffic within a run; tape writes favour the cells the head can reach.
  function automatic tms_in_t side_item(int lo, int hi);
    int a_lo;
    int a_hi;
    a_lo = (lo < 0) ? 0 : lo;
    a_hi = (hi >= TAPE_CELLS) ? TAPE_CELLS - 1 : hi;
    case ($urandom_range(0, 4))
      0: return tape_write($urandom_range(a_lo, a_hi), pick_small());
      1: return tape_write($urandom_range(0, TAPE_CELLS - 1), 8'($urandom));
      2: return tape_read(written_cells[$urandom_range(0, written_cells.size() - 1)]);
      3: return random_rule($urandom_range(0, RULE_SLOTS - 1));
      default: return random_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
    endcase
  endfunction

  task automatic send(input tms_in_t item);
    if (gap_max > 0 && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (item.op <= OP_RD_TAPE) items_sent++;
    if (item.op == OP_WR_TAPE && !tape_done[item.tape_address]) begin
      tape_done[item.tape_address] = 1'b1;
      written_cells.push_back(int'(item.tape_address));
    end
    if (item.op == OP_WR_RULE) rule_done[item.rule_index] = 1'b1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_put(reg_idx_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DW'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_registers(int tlen, int rcnt, int shead);
    int lim;
    drain();
    cfg_put(REG_TAPE_LENGTH, tlen);
    cfg_put(REG_RULE_COUNT, rcnt);
    cfg_put(REG_START_HEAD, shead);
    cfg_valid <= 1'b0;
    cur_tlen = tlen;
    cur_rcnt = rcnt;
    cur_start = shead;
    lim = (rcnt > RULE_SLOTS) ? RULE_SLOTS : rcnt;
    for (int i = 0; i < lim; i++) begin
      if (!rule_done[i]) send(random_rule(i));
    end
  endtask

  // Restart, then a run of steps; every cell the head can reach is written first.
  task automatic machine_run(int steps);
    int lo;
    int hi;
    lo = cur_start - steps - 1;
    hi = cur_start + steps + 1;
    for (int a = lo; a <= hi; a++) begin
      if (a >= 0 && a < TAPE_CELLS && !tape_done[a]) send(tape_write(a, pick_small()));
    end
    send(random_item(OP_RESTART));
    for (int k = 0; k < steps; k++) begin
      if ($urandom_range(0, 99) < 15) send(side_item(lo, hi));
      send(random_item(OP_STEP));
    end
  endtask

  initial begin : result_sink
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && items_sent >= HOLD_AT && in_valid) begin
        held = 1'b1;
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int tlen;
    int rcnt;
    int shead;
    int used;
    int phase;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TAPE_LENGTH;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: spare ops, tape extremes, halting with no rules, moving off
    // the left and right ends, and a restart beyond the tape.
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) send(random_item(3'(op)));
    send(random_item(OP_RESTART));
    send(tape_write(0, 8'hFF));
    send(tape_write(1, 8'h00));
    send(tape_write(TAPE_CELLS - 1, 8'h80));
    send(tape_read(0));
    send(tape_read(TAPE_CELLS - 1));
    send(random_item(OP_STEP));
    send(rule_entry(0, 8'h00, 8'hFF, 8'h00, 1'b0, 8'hFF));
    send(rule_entry(RULE_SLOTS - 1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF));
    set_registers(1024, 1, 0);
    send(random_item(OP_STEP));
    send(random_item(OP_STEP));
    send(random_item(OP_RESTART));
    send(random_item(OP_STEP));
    send(rule_entry(0, 8'h00, 8'h00, 8'h07, 1'b1, 8'h01));
    set_registers(2, 1, 1);
    send(random_item(OP_RESTART));
    send(random_item(OP_STEP));
    send(random_item(OP_STEP));
    set_registers(2, 1, 2);
    send(random_item(OP_RESTART));
    send(random_item(OP_STEP));

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: begin tlen = 0;    rcnt = 64;  shead = 0;    end
        1: begin tlen = 2047; rcnt = 127; shead = 1023; end
        2: begin tlen = 1;    rcnt = 0;   shead = 0;    end
        3: begin tlen = 1024; rcnt = 64;  shead = 1023; end
        default: begin
          case ($urandom_range(0, 9))
            0: tlen = 0;
            1: tlen = 1;
            2: tlen = 1024;
            3: tlen = 2047;
            4: tlen = $urandom_range(1025, 2047);
            5: tlen = $urandom_range(1, 1024);
            default: tlen = $urandom_range(2, 24);
          endcase
          case ($urandom_range(0, 7))
            0: rcnt = 0;
            1: rcnt = 1;
            2: rcnt = 64;
            3: rcnt = $urandom_range(65, 127);
            default: rcnt = $urandom_range(2, 64);
          endcase
          used = (tlen > TAPE_CELLS) ? TAPE_CELLS : tlen;
          case ($urandom_range(0, 5))
            0: shead = 0;
            1: shead = 1023;
            2: shead = (used > 0) ? used - 1 : 0;
            3: shead = (used > 1023) ? 1023 : used;
            default: shead = (used > 0) ? $urandom_range(0, used - 1) : $urandom_range(0, 1023);
          endcase
        end
      endcase
      set_registers(tlen, rcnt, shead);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 10;
        2: stall_pct = 35;
        default: stall_pct = 70;
      endcase
      repeat ($urandom_range(1, 4)) machine_run($urandom_range(1, 24));
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
